### sv/polyphase_rational_resampler_core_assert.svh
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Shared concurrent assertion forms for the resampler modules. Each macro
// expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_RATIONAL_RESAMPLER_CORE_ASSERT_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PRR_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PRR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/prr_pkg.sv
// ----------------------------------------------------------------------------
// Resampler package
// Widths, codes and shared types of the polyphase rational resampler.
// ----------------------------------------------------------------------------
package prr_pkg;

  localparam int MAX_PHASES  = 64;
  localparam int MAX_TAPS    = 512;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;

  localparam int OP_W      = 2;
  localparam int PHASE_W   = 6;
  localparam int TAP_IDX_W = 9;

  localparam int DOWN_W     = 10;
  localparam int UP_W       = 7;
  localparam int HALF_W     = 8;
  localparam int DOWN_LIMIT = 512;

  // The tap sum before clamping is at most 2*255 + 512 = 1022.
  localparam int K_W = 10;

  localparam int CREDIT_W  = 20;
  localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W     = PROD_W + K_W;
  localparam int RND_SHIFT = COEF_BITS - 2;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_WR_COEF = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_PAD     = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_DOWN_FACTOR = 2'd0,
    REG_UP_FACTOR   = 2'd1,
    REG_HALF_WIDTH  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PHASE,
    S_MAC,
    S_DRAIN,
    S_ROUND,
    S_EMIT
  } seq_state_e;

  // Effective ratio settings derived from the register file.
  typedef struct packed {
    logic [DOWN_W-1:0] down;
    logic [UP_W-1:0]   up;
    logic [K_W-1:0]    taps;
    logic [DOWN_W-1:0] reload;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic zero_tap;
    logic round;
  } mac_ctl_t;

endpackage

### sv/prr_in_if.sv
// ----------------------------------------------------------------------------
// Resampler input channel
// Valid/ready channel carrying coefficient writes, samples, pads and restarts.
// ----------------------------------------------------------------------------
interface prr_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [prr_pkg::OP_W-1:0]                   op;
  logic [prr_pkg::PHASE_W-1:0]                phase_index;
  logic [prr_pkg::TAP_IDX_W-1:0]              tap_index;
  logic signed [prr_pkg::COEF_BITS-1:0]       coefficient_value;
  logic signed [prr_pkg::SAMPLE_BITS-1:0]     sample_value;

  modport source (
    output valid, op, phase_index, tap_index, coefficient_value, sample_value,
    input  ready
  );

  modport sink (
    input  valid, op, phase_index, tap_index, coefficient_value, sample_value,
    output ready
  );
endinterface

### sv/prr_out_if.sv
// ----------------------------------------------------------------------------
// Resampler output channel
// Valid/ready channel carrying resampled outputs.
// ----------------------------------------------------------------------------
interface prr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [prr_pkg::SAMPLE_BITS-1:0] output_sample;
  logic [prr_pkg::PHASE_W-1:0]            output_phase;
  logic                                   last_of_run;

  modport source (
    output valid, output_sample, output_phase, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, output_sample, output_phase, last_of_run,
    output ready
  );
endinterface

### sv/polyphase_rational_resampler_core.sv
// ----------------------------------------------------------------------------
// Polyphase rational resampler core
// Resamples a Q1.15 stream by up/down with a bank of FIR phases that share
// one multiply-accumulate unit under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel  Kind          Direction  Moves
//   in_i     valid/ready   in         coefficient write, sample, pad, restart
//   out_o    valid/ready   out        resampled sample, phase, last flag
//   APB      psel/penable  in/out     down_factor, up_factor, half_width
//
// A transaction that does not complete a step leaves the input ready. A step
// emits up to up_factor outputs; each runs the MAC over K taps, where K is the
// tap count, reading one delay line and one coefficient entry per cycle.
// The input is not ready while a step runs and in the cycle after a register
// write. The output register lets the next input transaction in while the
// last result waits; a stalled output holds the sequencer in its emit state.
// Reset needs no clearing pass: a fill count masks delay line entries that
// were not written since the last restart.
//
module polyphase_rational_resampler_core #(
  parameter int MAX_PHASES = prr_pkg::MAX_PHASES,
  parameter int MAX_TAPS   = prr_pkg::MAX_TAPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  prr_in_if.sink                          in_i,
  prr_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [prr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [prr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int TAP_W = $clog2(MAX_TAPS);
  localparam int CA_W  = $clog2(MAX_PHASES * MAX_TAPS);

  prr_pkg::cfg_t                          cfg;
  logic                                   cfg_restart;
  prr_pkg::mac_ctl_t                      mac_ctl;
  logic                                   mac_busy;
  logic signed [prr_pkg::SAMPLE_BITS-1:0] mac_result;

  logic                                   dl_we, dl_re;
  logic [TAP_W-1:0]                       dl_waddr, dl_raddr;
  logic [prr_pkg::SAMPLE_BITS-1:0]        dl_wdata, dl_rdata;
  logic                                   cf_we, cf_re;
  logic [CA_W-1:0]                        cf_waddr, cf_raddr;
  logic [prr_pkg::COEF_BITS-1:0]          cf_wdata, cf_rdata;

  prr_cfg #(
    .MAX_PHASES (MAX_PHASES),
    .MAX_TAPS   (MAX_TAPS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (cfg_restart)
  );

  prr_seq #(
    .MAX_PHASES (MAX_PHASES),
    .MAX_TAPS   (MAX_TAPS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (cfg_restart),
    .in_i         (in_i),
    .out_o        (out_o),
    .dl_we_o      (dl_we),
    .dl_waddr_o   (dl_waddr),
    .dl_wdata_o   (dl_wdata),
    .dl_re_o      (dl_re),
    .dl_raddr_o   (dl_raddr),
    .cf_we_o      (cf_we),
    .cf_waddr_o   (cf_waddr),
    .cf_wdata_o   (cf_wdata),
    .cf_re_o      (cf_re),
    .cf_raddr_o   (cf_raddr),
    .mac_ctl_o    (mac_ctl),
    .mac_busy_i   (mac_busy),
    .mac_result_i (mac_result)
  );

  prr_ram #(
    .WIDTH (prr_pkg::SAMPLE_BITS),
    .DEPTH (MAX_TAPS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .re_i    (dl_re),
    .raddr_i (dl_raddr),
    .rdata_o (dl_rdata)
  );

  prr_ram #(
    .WIDTH (prr_pkg::COEF_BITS),
    .DEPTH (MAX_PHASES * MAX_TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cf_we),
    .waddr_i (cf_waddr),
    .wdata_i (cf_wdata),
    .re_i    (cf_re),
    .raddr_i (cf_raddr),
    .rdata_o (cf_rdata)
  );

  prr_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .dline_i  (dl_rdata),
    .coef_i   (cf_rdata),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

endmodule

### sv/prr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/prr_cfg.sv
// ----------------------------------------------------------------------------
// Resampler register file
// APB-style register port for the ratio settings; derives the effective
// factors, the tap count and the first-step countdown.
// ----------------------------------------------------------------------------
module prr_cfg #(
  parameter int MAX_PHASES = prr_pkg::MAX_PHASES,
  parameter int MAX_TAPS   = prr_pkg::MAX_TAPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [prr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [prr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output prr_pkg::cfg_t                   cfg_o,
  output logic                            restart_o
);

  logic [prr_pkg::DOWN_W-1:0] down_q;
  logic [prr_pkg::UP_W-1:0]   up_q;
  logic [prr_pkg::HALF_W-1:0] half_q;
  logic                       restart_q;

  logic                       wr_en;
  prr_pkg::reg_e              reg_sel;
  logic [prr_pkg::DOWN_W-1:0] down_eff;
  logic [prr_pkg::UP_W-1:0]   up_eff;
  logic [prr_pkg::K_W-1:0]    taps_sum;
  logic [prr_pkg::K_W-1:0]    taps;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = prr_pkg::reg_e'(paddr[prr_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q    <= prr_pkg::DOWN_W'(1);
      up_q      <= prr_pkg::UP_W'(1);
      half_q    <= '0;
      restart_q <= 1'b0;
    end else begin
      restart_q <= 1'b0;
      if (wr_en) begin
        case (reg_sel)
          prr_pkg::REG_DOWN_FACTOR: begin
            down_q    <= pwdata[prr_pkg::DOWN_W-1:0];
            restart_q <= 1'b1;
          end
          prr_pkg::REG_UP_FACTOR: begin
            up_q      <= pwdata[prr_pkg::UP_W-1:0];
            restart_q <= 1'b1;
          end
          prr_pkg::REG_HALF_WIDTH: begin
            half_q    <= pwdata[prr_pkg::HALF_W-1:0];
            restart_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      prr_pkg::REG_DOWN_FACTOR: prdata = prr_pkg::APB_DATA_W'(down_q);
      prr_pkg::REG_UP_FACTOR:   prdata = prr_pkg::APB_DATA_W'(up_q);
      prr_pkg::REG_HALF_WIDTH:  prdata = prr_pkg::APB_DATA_W'(half_q);
      default:                  prdata = '0;
    endcase
  end

  // A zero factor acts as one; large factors are clamped.
  always_comb begin
    if (down_q == '0) begin
      down_eff = prr_pkg::DOWN_W'(1);
    end else if (int'(down_q) > prr_pkg::DOWN_LIMIT) begin
      down_eff = prr_pkg::DOWN_W'(prr_pkg::DOWN_LIMIT);
    end else begin
      down_eff = down_q;
    end

    if (up_q == '0) begin
      up_eff = prr_pkg::UP_W'(1);
    end else if (int'(up_q) > MAX_PHASES) begin
      up_eff = prr_pkg::UP_W'(MAX_PHASES);
    end else begin
      up_eff = up_q;
    end

    taps_sum = prr_pkg::K_W'({half_q, 1'b0}) + prr_pkg::K_W'(down_eff);
    if (int'(taps_sum) > MAX_TAPS) begin
      taps = prr_pkg::K_W'(MAX_TAPS);
    end else begin
      taps = taps_sum;
    end

    cfg_o.down = down_eff;
    cfg_o.up   = up_eff;
    cfg_o.taps = taps;
    if (taps > prr_pkg::K_W'(half_q)) begin
      cfg_o.reload = prr_pkg::DOWN_W'(taps - prr_pkg::K_W'(half_q));
    end else begin
      cfg_o.reload = prr_pkg::DOWN_W'(1);
    end
  end

  // The restart follows the write in the cycle after it, so that it sees the new values.
  assign restart_o = restart_q;

endmodule

### sv/prr_mac.sv
// ----------------------------------------------------------------------------
// Resampler multiply-accumulate unit
// Shared pipelined MAC: registered product, wide accumulator and a rounding
// and saturation stage for the finished dot product.
// ----------------------------------------------------------------------------
module prr_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  prr_pkg::mac_ctl_t                       ctl_i,
  input  logic signed [prr_pkg::SAMPLE_BITS-1:0]  dline_i,
  input  logic signed [prr_pkg::COEF_BITS-1:0]    coef_i,
  output logic                                    busy_o,
  output logic signed [prr_pkg::SAMPLE_BITS-1:0]  result_o
);

  localparam int SUM_W = prr_pkg::ACC_W + 1;
  localparam int Q_W   = SUM_W - prr_pkg::RND_SHIFT;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((2 ** (prr_pkg::SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(2 ** (prr_pkg::SAMPLE_BITS - 1)));
  localparam logic signed [SUM_W-1:0] BIAS = SUM_W'(2 ** (prr_pkg::RND_SHIFT - 1));

  logic                                   v1_q, v2_q, z1_q;
  logic signed [prr_pkg::PROD_W-1:0]      prod_q;
  logic signed [prr_pkg::ACC_W-1:0]       acc_q;
  logic signed [prr_pkg::SAMPLE_BITS-1:0] res_q;

  logic signed [SUM_W-1:0]                biased;
  logic signed [Q_W-1:0]                  quot;
  logic signed [prr_pkg::SAMPLE_BITS-1:0] sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue;
      v2_q <= v1_q;
    end
  end

  // The zero flag travels with the read so that taps before the first
  // sample since restart contribute nothing.
  always_ff @(posedge clk_i) begin
    z1_q <= ctl_i.zero_tap;
    if (z1_q) begin
      prod_q <= '0;
    end else begin
      prod_q <= dline_i * coef_i;
    end
    if (ctl_i.clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + prr_pkg::ACC_W'(prod_q);
    end
    if (ctl_i.round) begin
      res_q <= sat;
    end
  end

  // Round half toward positive infinity, then clamp to the sample range.
  always_comb begin
    biased = SUM_W'(acc_q) + BIAS;
    quot   = biased[SUM_W-1:prr_pkg::RND_SHIFT];
    if (quot > Q_MAX) begin
      sat = prr_pkg::SAMPLE_BITS'(Q_MAX);
    end else if (quot < Q_MIN) begin
      sat = prr_pkg::SAMPLE_BITS'(Q_MIN);
    end else begin
      sat = prr_pkg::SAMPLE_BITS'(quot);
    end
  end

  assign busy_o   = v1_q | v2_q;
  assign result_o = res_q;

endmodule

### sv/prr_seq.sv
// ----------------------------------------------------------------------------
// Resampler sequencer
// Takes input transactions, keeps the delay line pointer, fill count, step
// countdown and output credit, and walks the MAC over each phase's taps.
// ----------------------------------------------------------------------------
`include "polyphase_rational_resampler_core_assert.svh"

module prr_seq #(
  parameter int MAX_PHASES = prr_pkg::MAX_PHASES,
  parameter int MAX_TAPS   = prr_pkg::MAX_TAPS,
  localparam int TAP_W     = $clog2(MAX_TAPS),
  localparam int CA_W      = $clog2(MAX_PHASES * MAX_TAPS)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  prr_pkg::cfg_t                          cfg_i,
  input  logic                                   restart_i,
  prr_in_if.sink                                 in_i,
  prr_out_if.source                              out_o,
  output logic                                   dl_we_o,
  output logic [TAP_W-1:0]                       dl_waddr_o,
  output logic [prr_pkg::SAMPLE_BITS-1:0]        dl_wdata_o,
  output logic                                   dl_re_o,
  output logic [TAP_W-1:0]                       dl_raddr_o,
  output logic                                   cf_we_o,
  output logic [CA_W-1:0]                        cf_waddr_o,
  output logic [prr_pkg::COEF_BITS-1:0]          cf_wdata_o,
  output logic                                   cf_re_o,
  output logic [CA_W-1:0]                        cf_raddr_o,
  output prr_pkg::mac_ctl_t                      mac_ctl_o,
  input  logic                                   mac_busy_i,
  input  logic signed [prr_pkg::SAMPLE_BITS-1:0] mac_result_i
);

  localparam int SW    = ((TAP_W > prr_pkg::K_W) ? TAP_W : prr_pkg::K_W) + 2;
  localparam int DLT_W = prr_pkg::DOWN_W + 2;

  function automatic logic signed [prr_pkg::CREDIT_W-1:0] credit_add(
    input logic signed [prr_pkg::CREDIT_W-1:0] c,
    input logic signed [DLT_W-1:0]             d
  );
    logic signed [prr_pkg::CREDIT_W:0]   s;
    logic signed [prr_pkg::CREDIT_W-1:0] r;
    s = (prr_pkg::CREDIT_W + 1)'(c) + (prr_pkg::CREDIT_W + 1)'(d);
    if (s[prr_pkg::CREDIT_W] != s[prr_pkg::CREDIT_W-1]) begin
      r = s[prr_pkg::CREDIT_W] ? {1'b1, {(prr_pkg::CREDIT_W - 1){1'b0}}}
                                : {1'b0, {(prr_pkg::CREDIT_W - 1){1'b1}}};
    end else begin
      r = s[prr_pkg::CREDIT_W-1:0];
    end
    return r;
  endfunction

  prr_pkg::seq_state_e state_q, state_d;

  logic [TAP_W-1:0]                       wp_q, wp_d;
  logic [prr_pkg::K_W-1:0]                fill_q, fill_d;
  logic [prr_pkg::DOWN_W-1:0]             cnt_q, cnt_d;
  logic signed [prr_pkg::CREDIT_W-1:0]    credit_q, credit_d;
  logic                                   pad_q, pad_d;
  logic [prr_pkg::PHASE_W-1:0]            phase_q, phase_d;
  logic [CA_W-1:0]                        base_q, base_d;
  logic [prr_pkg::K_W-1:0]                tap_q, tap_d;
  logic [TAP_W-1:0]                       idx_q, idx_d;
  logic [prr_pkg::K_W-1:0]                zt_q, zt_d;
  logic                                   out_valid_q, out_valid_d;
  logic signed [prr_pkg::SAMPLE_BITS-1:0] out_sample_q;
  logic [prr_pkg::PHASE_W-1:0]            out_phase_q;
  logic                                   out_last_q, out_last_d;

  logic                                   in_ready;
  logic                                   accept;
  prr_pkg::op_e                           op;
  logic                                   push;
  logic                                   restart;
  logic                                   out_load;
  logic                                   last;
  logic [SW-1:0]                          start_sum;
  logic [TAP_W-1:0]                       start_idx;
  logic signed [DLT_W-1:0]                up_dlt, down_dlt;
  logic signed [prr_pkg::CREDIT_W-1:0]    credit_sub;

  assign in_ready   = (state_q == prr_pkg::S_IDLE) && !restart_i;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;
  assign op         = prr_pkg::op_e'(in_i.op);
  assign push       = accept && (((op == prr_pkg::OP_SAMPLE) && !pad_q) ||
                                 (op == prr_pkg::OP_PAD));
  assign restart    = restart_i || (accept && (op == prr_pkg::OP_RESTART));

  assign up_dlt     = signed'(DLT_W'(cfg_i.up));
  assign down_dlt   = -signed'(DLT_W'(cfg_i.down));
  assign credit_sub = credit_add(credit_q, down_dlt);

  // Delay line writes happen in the accepting cycle.
  assign dl_we_o    = push;
  assign dl_waddr_o = wp_q;
  assign dl_wdata_o = (op == prr_pkg::OP_PAD) ? '0 : in_i.sample_value;

  assign cf_we_o    = accept && (op == prr_pkg::OP_WR_COEF) &&
                      (int'(in_i.phase_index) < MAX_PHASES) &&
                      (int'(in_i.tap_index) < MAX_TAPS);
  assign cf_waddr_o = CA_W'(in_i.phase_index) * CA_W'(MAX_TAPS) + CA_W'(in_i.tap_index);
  assign cf_wdata_o = in_i.coefficient_value;

  assign dl_raddr_o = idx_q;
  assign cf_raddr_o = base_q + CA_W'(tap_q);

  // Oldest sample of the window: the write pointer minus the tap count, wrapped.
  always_comb begin
    start_sum = SW'(wp_q) + SW'(MAX_TAPS) - SW'(cfg_i.taps);
    if (start_sum >= SW'(MAX_TAPS)) begin
      start_sum = start_sum - SW'(MAX_TAPS);
    end
    start_idx = TAP_W'(start_sum);
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    credit_d    = credit_q;
    pad_d       = pad_q;
    phase_d     = phase_q;
    base_d      = base_q;
    tap_d       = tap_q;
    idx_d       = idx_q;
    zt_d        = zt_q;
    out_last_d  = out_last_q;
    out_load    = 1'b0;
    last        = 1'b0;
    mac_ctl_o   = '0;
    dl_re_o     = 1'b0;
    cf_re_o     = 1'b0;

    case (state_q)
      prr_pkg::S_IDLE: begin
        if (restart) begin
          wp_d     = '0;
          fill_d   = '0;
          credit_d = '0;
          pad_d    = 1'b0;
          cnt_d    = cfg_i.reload;
        end else if (push) begin
          if (op == prr_pkg::OP_SAMPLE) begin
            credit_d = credit_add(credit_q, up_dlt);
          end else begin
            pad_d = 1'b1;
          end
          wp_d   = (wp_q == TAP_W'(MAX_TAPS - 1)) ? '0 : wp_q + TAP_W'(1);
          fill_d = (fill_q == '1) ? fill_q : fill_q + prr_pkg::K_W'(1);
          if (cnt_q > prr_pkg::DOWN_W'(1)) begin
            cnt_d = cnt_q - prr_pkg::DOWN_W'(1);
          end else begin
            cnt_d   = cfg_i.down;
            phase_d = '0;
            base_d  = '0;
            state_d = prr_pkg::S_PHASE;
          end
        end
      end
      prr_pkg::S_PHASE: begin
        if (credit_q <= 0) begin
          state_d = prr_pkg::S_IDLE;
        end else begin
          mac_ctl_o.clear = 1'b1;
          tap_d = '0;
          idx_d = start_idx;
          zt_d  = (fill_q >= cfg_i.taps) ? '0 : cfg_i.taps - fill_q;
          state_d = prr_pkg::S_MAC;
        end
      end
      prr_pkg::S_MAC: begin
        dl_re_o            = 1'b1;
        cf_re_o            = 1'b1;
        mac_ctl_o.issue    = 1'b1;
        mac_ctl_o.zero_tap = tap_q < zt_q;
        idx_d = (idx_q == TAP_W'(MAX_TAPS - 1)) ? '0 : idx_q + TAP_W'(1);
        tap_d = tap_q + prr_pkg::K_W'(1);
        if (tap_q == cfg_i.taps - prr_pkg::K_W'(1)) begin
          state_d = prr_pkg::S_DRAIN;
        end
      end
      prr_pkg::S_DRAIN: begin
        if (!mac_busy_i) begin
          state_d = prr_pkg::S_ROUND;
        end
      end
      prr_pkg::S_ROUND: begin
        mac_ctl_o.round = 1'b1;
        state_d = prr_pkg::S_EMIT;
      end
      prr_pkg::S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load   = 1'b1;
          credit_d   = credit_sub;
          last       = (prr_pkg::UP_W'(phase_q) + prr_pkg::UP_W'(1) == cfg_i.up) ||
                       (credit_sub <= 0);
          out_last_d = last;
          if (last) begin
            state_d = prr_pkg::S_IDLE;
          end else begin
            phase_d = phase_q + prr_pkg::PHASE_W'(1);
            base_d  = base_q + CA_W'(MAX_TAPS);
            state_d = prr_pkg::S_PHASE;
          end
        end
      end
      default: begin
        state_d = prr_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prr_pkg::S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      cnt_q       <= prr_pkg::DOWN_W'(1);
      credit_q    <= '0;
      pad_q       <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      credit_q    <= credit_d;
      pad_q       <= pad_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    tap_q      <= tap_d;
    idx_q      <= idx_d;
    zt_q       <= zt_d;
    out_last_q <= out_last_d;
    if (out_load) begin
      out_sample_q <= mac_result_i;
      out_phase_q  <= phase_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.output_sample = out_sample_q;
  assign out_o.output_phase  = out_phase_q;
  assign out_o.last_of_run   = out_last_q;

  `PRR_ASSERT_IMPL(a_tap_in_window, state_q == prr_pkg::S_MAC, tap_q < cfg_i.taps, "tap counter left the window")
  `PRR_ASSERT_IMPL(a_emit_needs_credit, out_load, credit_q > 0, "output emitted without credit")
  `PRR_ASSERT_IMPL(a_phase_in_range, state_q != prr_pkg::S_IDLE, prr_pkg::UP_W'(phase_q) < cfg_i.up, "phase beyond up factor")
  `PRR_ASSERT_NEXT(a_last_tap_in_flight, (state_q == prr_pkg::S_MAC) && (tap_q == cfg_i.taps - prr_pkg::K_W'(1)), mac_busy_i, "last tap not in MAC pipeline")
  `PRR_ASSERT_IMPL(a_round_after_drain, state_q == prr_pkg::S_ROUND, !mac_busy_i, "rounding before accumulation finished")

endmodule

### dv/polyphase_rational_resampler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Polyphase rational resampler core testbench
// Drives coefficient writes, samples, pads and restarts under several ratio
// settings, predicts the resampled outputs from a directed table and a behavioral
// polyphase FIR of its own and checks each output transaction field by field, in order.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler_core_tb;
  import prr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int N_PHASES    = 12;
  localparam int SAT_HI      = (1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_LO      = -(1 <<< (SAMPLE_BITS - 1));
  localparam int CREDIT_HI   = (1 <<< (CREDIT_W - 1)) - 1;
  localparam int CREDIT_LO   = -(1 <<< (CREDIT_W - 1));

  // Ratio settings of the stream phases. A half width of 255 marks a long
  // phase that sends only samples and coefficient writes before its closing pad run.
  localparam int PH_DOWN [N_PHASES] = '{3, 2, 0, 1, 5, 1023, 2, 7, 4, 9, 512, 1};
  localparam int PH_UP   [N_PHASES] = '{2, 3, 0, 100, 4, 1, 64, 5, 7, 2, 1, 1};
  localparam int PH_HALF [N_PHASES] = '{2, 1, 3, 0, 6, 255, 1, 3, 2, 4, 255, 0};
  localparam int PH_LEN  [N_PHASES] = '{30, 30, 25, 16, 30, 262, 12, 30, 30, 30, 262, 25};

  typedef struct {
    op_e                           op;
    logic [PHASE_W-1:0]            phase;
    logic [TAP_IDX_W-1:0]          tap;
    logic signed [COEF_BITS-1:0]   coef;
    logic signed [SAMPLE_BITS-1:0] sample;
    bit                            typed;
    int                            typed_cnt;
    logic signed [SAMPLE_BITS-1:0] typed_val;
  } item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [PHASE_W-1:0]            phase;
    logic                          last;
  } out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  prr_in_if  in_ch ();
  prr_out_if out_ch ();

  polyphase_rational_resampler_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Filter state as the block should hold it.
  logic signed [SAMPLE_BITS-1:0] dline [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coefs [MAX_PHASES * MAX_TAPS];
  bit                            coef_set [MAX_PHASES * MAX_TAPS];
  int                            wr_ptr;
  int                            countdown;
  int                            credit;
  bit                            padding;
  logic [DOWN_W-1:0]             down_reg = 1;
  logic [UP_W-1:0]               up_reg = 1;
  logic [HALF_W-1:0]             half_reg = 0;

  item_t offered [$];
  out_t  step_outputs [$];
  out_t  pending_outputs [$];
  item_t dir_tab [25];
  int    errors = 0;
  int    results_seen = 0;
  int    cycles = 0;
  int    burst_left = 0;
  bit    streaming = 1'b0;

  function automatic int ratio_down();
    if (down_reg == 0) return 1;
    return (int'(down_reg) > DOWN_LIMIT) ? DOWN_LIMIT : int'(down_reg);
  endfunction

  function automatic int ratio_up();
    if (up_reg == 0) return 1;
    return (int'(up_reg) > MAX_PHASES) ? MAX_PHASES : int'(up_reg);
  endfunction

  function automatic int tap_count();
    int k;
    k = 2 * int'(half_reg) + ratio_down();
    return (k > MAX_TAPS) ? MAX_TAPS : k;
  endfunction

  function automatic void add_credit(int d);
    credit = credit + d;
    if (credit > CREDIT_HI) credit = CREDIT_HI;
    if (credit < CREDIT_LO) credit = CREDIT_LO;
  endfunction

  function automatic void restart_stream();
    int k;
    foreach (dline[i]) dline[i] = '0;
    k = tap_count();
    wr_ptr = 0;
    countdown = (k > int'(half_reg)) ? k - int'(half_reg) : 1;
    credit = 0;
    padding = 1'b0;
  endfunction

  // Pushes one value into the delay line; when the countdown runs out, every
  // phase with credit left computes a dot product over the newest K values.
  function automatic void shift_in(logic signed [SAMPLE_BITS-1:0] v);
    int     k;
    int     up;
    int     down;
    int     idx;
    longint acc;
    longint q;
    out_t   r;
    dline[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % MAX_TAPS;
    if (countdown > 1) begin
      countdown--;
      return;
    end
    down = ratio_down();
    up = ratio_up();
    k = tap_count();
    countdown = down;
    for (int p = 0; p < up && credit > 0; p++) begin
      acc = 0;
      idx = (wr_ptr + MAX_TAPS - k) % MAX_TAPS;
      for (int t = 0; t < k; t++) begin
        acc += longint'(dline[idx]) * longint'(coefs[p * MAX_TAPS + t]);
        idx = (idx + 1) % MAX_TAPS;
      end
      q = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      r.value = q[SAMPLE_BITS-1:0];
      r.phase = p[PHASE_W-1:0];
      r.last = 1'b0;
      step_outputs.push_back(r);
      add_credit(-down);
    end
    if (step_outputs.size() != 0) step_outputs[step_outputs.size() - 1].last = 1'b1;
  endfunction

  function automatic void resample(item_t it);
    step_outputs.delete();
    case (it.op)
      OP_WR_COEF: coefs[{it.phase, it.tap}] = it.coef;
      OP_SAMPLE: begin
        if (!padding) begin
          add_credit(ratio_up());
          shift_in(it.sample);
        end
      end
      OP_PAD: begin
        padding = 1'b1;
        shift_in('0);
      end
      default: restart_stream();
    endcase
  endfunction

  function automatic item_t make_item(op_e op);
    item_t it;
    it.op = op;
    it.phase = $urandom();
    it.tap = $urandom();
    it.coef = $urandom();
    it.sample = $urandom();
    if ($urandom_range(0, 9) == 0) it.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    it.typed = 1'b0;
    it.typed_cnt = 0;
    it.typed_val = '0;
    return it;
  endfunction

  function automatic int drain_cycles();
    return (tap_count() + 6) * 4 + 64;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Input and output monitors share one block so that a prediction is always
  // in place before the outputs it causes can be compared.
  always @(posedge clk_i) begin
    item_t it;
    out_t  got;
    out_t  want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        it = offered.pop_front();
        resample(it);
        if (it.typed) begin
          if (it.typed_cnt == 1) pending_outputs.push_back('{it.typed_val, '0, 1'b1});
        end else begin
          foreach (step_outputs[i]) pending_outputs.push_back(step_outputs[i]);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.output_sample, out_ch.output_phase, out_ch.last_of_run};
        results_seen++;
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected output sample %0d phase %0d last %0b",
                   $time, got.value, got.phase, got.last);
          errors++;
        end else begin
          want = pending_outputs.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: output_sample expected %0d actual %0d",
                     $time, want.value, got.value);
            errors++;
          end
          if (got.phase !== want.phase) begin
            $display("%0t: output_phase expected %0d actual %0d",
                     $time, want.phase, got.phase);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Output side: ready follows a pattern that changes every so often, and
  // once, while items keep coming, it holds off long enough to back up the
  // whole block.
  initial begin
    int mode;
    int left;
    bit held;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && streaming && results_seen >= 100) begin
        held = 1'b1;
        out_ch.ready = 1'b0;
        repeat (800) @(negedge clk_i);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        2: out_ch.ready = ($urandom_range(0, 3) == 0);
        default: out_ch.ready = ~out_ch.ready;
      endcase
    end
  end

  // Every driving task starts and ends just after a falling edge.
  task automatic send(item_t it);
    if (it.op == OP_WR_COEF) coef_set[{it.phase, it.tap}] = 1'b1;
    offered.push_back(it);
    in_ch.op = it.op;
    in_ch.phase_index = it.phase;
    in_ch.tap_index = it.tap;
    in_ch.coefficient_value = it.coef;
    in_ch.sample_value = it.sample;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 15);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    in_ch.valid = 1'b0;
    while (offered.size() != 0 || pending_outputs.size() != 0) @(negedge clk_i);
    repeat (drain_cycles()) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [APB_DATA_W-1:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_DOWN_FACTOR: down_reg = val[DOWN_W-1:0];
      REG_UP_FACTOR:   up_reg = val[UP_W-1:0];
      default:         half_reg = val[HALF_W-1:0];
    endcase
    restart_stream();
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Small coefficients keep long filters out of saturation; full-range ones
  // drive it hard.
  task automatic write_coef(int ph, int tp, bit full);
    item_t it;
    int    span;
    it = make_item(OP_WR_COEF);
    span = 65536 / tap_count() + 16;
    it.phase = ph[PHASE_W-1:0];
    it.tap = tp[TAP_IDX_W-1:0];
    if (!full) it.coef = int'($urandom_range(0, 2 * span)) - span;
    send(it);
    pace();
  endtask

  task automatic pad_run(int len);
    repeat (len) begin
      send(make_item(OP_PAD));
      pace();
    end
    // Samples offered while padding must be dropped without a result.
    repeat ($urandom_range(0, 2)) begin
      send(make_item(OP_SAMPLE));
      pace();
    end
    send(make_item(OP_RESTART));
    pace();
  endtask

  task automatic run_phase(int d, int u, int h, int n);
    int  cnt;
    int  r;
    int  len;
    bit  long_fill;
    write_reg(REG_DOWN_FACTOR, d);
    write_reg(REG_UP_FACTOR, u);
    write_reg(REG_HALF_WIDTH, h);
    long_fill = (h == 255);
    // Every coefficient a step can read is written before the first sample.
    for (int p = 0; p < ratio_up(); p++) begin
      for (int t = 0; t < tap_count(); t++) begin
        if (!coef_set[p * MAX_TAPS + t]) write_coef(p, t, 1'b0);
      end
    end
    streaming = 1'b1;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 76 || (long_fill && r < 92)) begin
        send(make_item(OP_SAMPLE));
        pace();
        cnt++;
      end else if (r < 86 || long_fill) begin
        write_coef($urandom_range(0, MAX_PHASES - 1), $urandom_range(0, MAX_TAPS - 1),
                   $urandom_range(0, 1));
      end else if (r < 90) begin
        send(make_item(OP_RESTART));
        pace();
        cnt++;
      end else begin
        len = $urandom_range(1, ratio_down() + 3);
        pad_run(len);
        cnt += len;
      end
    end
    len = h + 2 * ratio_down();
    pad_run($urandom_range(1, (len > 40) ? 40 : len));
    streaming = 1'b0;
    settle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_RESTART;
    in_ch.phase_index = '0;
    in_ch.tap_index = '0;
    in_ch.coefficient_value = '0;
    in_ch.sample_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    restart_stream();

    // After reset one tap and one phase: each sample outside a pad run yields one
    // output, the sample times the single coefficient, rounded half up and saturated.
    dir_tab = '{
      '{OP_WR_COEF, 6'd0,  9'd0,   18'sh10000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh7fff, 1'b1, 1, 16'sh7fff},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh8000, 1'b1, 1, 16'sh8000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh0000, 1'b1, 1, 16'sh0000},
      '{OP_WR_COEF, 6'd0,  9'd0,   18'sh1ffff, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh7fff, 1'b1, 1, 16'sh7fff},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh8000, 1'b1, 1, 16'sh8000},
      '{OP_WR_COEF, 6'd0,  9'd0,   18'sh20000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh8000, 1'b1, 1, 16'sh7fff},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh7fff, 1'b1, 1, 16'sh8000},
      '{OP_WR_COEF, 6'd0,  9'd0,   18'sh00002, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh4000, 1'b1, 1, 16'sh0001},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'shc000, 1'b1, 1, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'shbfff, 1'b1, 1, 16'shffff},
      '{OP_WR_COEF, 6'd63, 9'd511, 18'sh15555, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_WR_COEF, 6'd21, 9'd170, 18'sh2aaaa, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_WR_COEF, 6'd0,  9'd0,   18'sh10000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_PAD,     6'd0,  9'd0,   18'sh00000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh7fff, 1'b1, 0, 16'sh0000},
      '{OP_RESTART, 6'd0,  9'd0,   18'sh00000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh1234, 1'b1, 1, 16'sh1234},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'sh5555, 1'b1, 1, 16'sh5555},
      '{OP_PAD,     6'd0,  9'd0,   18'sh00000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_RESTART, 6'd0,  9'd0,   18'sh00000, 16'sh0000, 1'b1, 0, 16'sh0000},
      '{OP_SAMPLE,  6'd0,  9'd0,   18'sh00000, 16'shaaaa, 1'b0, 0, 16'sh0000}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      send(dir_tab[i]);
      pace();
    end
    settle();

    for (int i = 0; i < N_PHASES; i++) run_phase(PH_DOWN[i], PH_UP[i], PH_HALF[i], PH_LEN[i]);
    repeat (3) begin
      run_phase($urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 6), 30);
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/prr_pkg.sv
sv/prr_in_if.sv
sv/prr_out_if.sv
sv/prr_ram.sv
sv/prr_cfg.sv
sv/prr_mac.sv
sv/prr_seq.sv
sv/polyphase_rational_resampler_core.sv
dv/polyphase_rational_resampler_core_tb.sv
